[src/ledsd_pkg.sv]
// ----------------------------------------------------------------------------
// ledsd_pkg
// Shared types and constants of the addressable LED strip driver.
// ----------------------------------------------------------------------------
package ledsd_pkg;

  // Store geometry.
  localparam int MAX_LEDS      = 64;
  localparam int LED_AW        = $clog2(MAX_LEDS);
  localparam int LED_CW        = LED_AW + 1;
  localparam int PIX_W         = 24;
  localparam int BITS_PER_LED  = 24;
  localparam int BIT_W         = 5;

  // Field widths.
  localparam int ACT_W         = 2;
  localparam int IDX_W         = 6;
  localparam int COLOR_W       = 8;
  localparam int LEDCNT_W      = 7;
  localparam int LATCH_W       = 12;
  localparam int CELLCLK_W     = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 8;

  // Register reset values.
  localparam logic [LEDCNT_W-1:0]  LED_COUNT_RST    = LEDCNT_W'(0);
  localparam logic [LATCH_W-1:0]   LATCH_LENGTH_RST = LATCH_W'(720);
  localparam logic [CELLCLK_W-1:0] CELL_CLOCKS_RST  = CELLCLK_W'(83);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_COUNT    = 2'd0,
    REG_LATCH_LENGTH = 2'd1,
    REG_CELL_CLOCKS  = 2'd2
  } reg_idx_t;

  // Request kinds.
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_SHOW  = 2'd3
  } action_t;

  // The three cells of one data bit.
  typedef enum logic [1:0] {
    SUB_HIGH = 2'd0,
    SUB_DATA = 2'd1,
    SUB_LOW  = 2'd2
  } sub_cell_t;

  // Controller to datapath.
  typedef struct packed {
    logic    accept;   // a request is taken this cycle
    action_t act;      // kind of the request
    logic    copy_rd;  // read one pixel word for the frame copy
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic copy_last;   // the copy read is at the last store entry
  } dp_status_t;

endpackage

[src/ledsd_ram.sv]
// ----------------------------------------------------------------------------
// ledsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ledsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ledsd_ctrl.sv]
// ----------------------------------------------------------------------------
// ledsd_ctrl
// Request sequencer: stream handshakes and the frame-copy sweep.
// ----------------------------------------------------------------------------
module ledsd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ledsd_pkg::ACT_W-1:0] in_action,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ledsd_pkg::ctrl_cmd_t   cmd,
  input  ledsd_pkg::dp_status_t  status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_FLUSH
  } state_t;

  state_t state;
  logic   accept;

  // A new request is taken only when idle and the result slot is free
  // or draining this cycle.
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.accept  = accept;
    cmd.act     = ledsd_pkg::action_t'(in_action);
    cmd.copy_rd = (state == ST_COPY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && (cmd.act == ledsd_pkg::ACT_SHOW)) begin
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (status.copy_last) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/ledsd_datapath.sv]
// ----------------------------------------------------------------------------
// ledsd_datapath
// Pixel and frame stores, configuration registers and the cell serializer.
// ----------------------------------------------------------------------------
module ledsd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ledsd_pkg::ctrl_cmd_t                 cmd,
  output ledsd_pkg::dp_status_t                status,
  input  logic [ledsd_pkg::IDX_W-1:0]          led_index,
  input  logic [ledsd_pkg::COLOR_W-1:0]        red,
  input  logic [ledsd_pkg::COLOR_W-1:0]        green,
  input  logic [ledsd_pkg::COLOR_W-1:0]        blue,
  input  logic                                 cfg_write,
  input  logic [ledsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ledsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                 res_pin,
  output logic                                 res_busy,
  output logic                                 res_done
);

  // Configuration registers.
  logic [ledsd_pkg::LEDCNT_W-1:0]  led_count;
  logic [ledsd_pkg::LATCH_W-1:0]   latch_length;
  logic [ledsd_pkg::CELLCLK_W-1:0] cell_clocks;

  // Pixel store bookkeeping; an entry that is not valid reads as zero.
  logic [ledsd_pkg::MAX_LEDS-1:0]  pix_valid;
  logic                            pix_we;
  logic [ledsd_pkg::PIX_W-1:0]     pix_wdata;
  logic [ledsd_pkg::PIX_W-1:0]     pix_rdata;

  // Copy sweep.
  logic [ledsd_pkg::LED_AW-1:0]    copy_cnt;
  logic                            copy_we;
  logic [ledsd_pkg::LED_AW-1:0]    copy_waddr;
  logic                            copy_vld;
  logic [ledsd_pkg::PIX_W-1:0]     frame_wdata;
  logic [ledsd_pkg::PIX_W-1:0]     frame_rdata;
  logic [ledsd_pkg::LED_AW-1:0]    frame_raddr;

  // Serializer state.
  logic [ledsd_pkg::LED_CW-1:0]    active_leds;
  logic [ledsd_pkg::LED_CW-1:0]    frame_leds, frame_leds_next;
  logic [ledsd_pkg::LATCH_W-1:0]   frame_latch, frame_latch_next;
  logic [ledsd_pkg::LED_CW-1:0]    led_num, led_num_next;
  logic [ledsd_pkg::BIT_W-1:0]     bit_num, bit_num_next;
  ledsd_pkg::sub_cell_t            sub_cell, sub_cell_next;
  logic [ledsd_pkg::LATCH_W-1:0]   latch_cnt, latch_cnt_next;
  logic                            in_latch, in_latch_next;
  logic [ledsd_pkg::CELLCLK_W-1:0] phase, phase_next;
  logic                            sending, sending_next;
  logic                            wire_level, wire_level_next;
  logic [ledsd_pkg::PIX_W-1:0]     shift_word, shift_word_next;
  logic                            done_now;

  logic [ledsd_pkg::CELLCLK_W-1:0] period;
  logic [ledsd_pkg::CELLCLK_W-1:0] phase_inc;
  logic                            cell_fire;
  logic [ledsd_pkg::LED_CW-1:0]    led_inc;
  logic                            last_cell;
  logic                            cell_level;

  assign active_leds = (led_count > ledsd_pkg::LEDCNT_W'(ledsd_pkg::MAX_LEDS))
                       ? ledsd_pkg::LED_CW'(ledsd_pkg::MAX_LEDS)
                       : ledsd_pkg::LED_CW'(led_count);

  assign pix_we    = cmd.accept && (cmd.act == ledsd_pkg::ACT_WRITE) &&
                     (ledsd_pkg::LED_CW'(led_index) < active_leds);
  assign pix_wdata = {green, red, blue};

  assign status.copy_last = (copy_cnt == ledsd_pkg::LED_AW'(ledsd_pkg::MAX_LEDS - 1));

  assign frame_wdata = copy_vld ? pix_rdata : '0;
  // Prefetch the word of the next LED so it is ready at the LED boundary.
  assign led_inc     = led_num + ledsd_pkg::LED_CW'(1);
  assign frame_raddr = led_inc[ledsd_pkg::LED_AW-1:0];

  ledsd_ram #(
    .WIDTH (ledsd_pkg::PIX_W),
    .DEPTH (ledsd_pkg::MAX_LEDS)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (led_index[ledsd_pkg::LED_AW-1:0]),
    .wdata (pix_wdata),
    .raddr (copy_cnt),
    .rdata (pix_rdata)
  );

  ledsd_ram #(
    .WIDTH (ledsd_pkg::PIX_W),
    .DEPTH (ledsd_pkg::MAX_LEDS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (copy_we),
    .waddr (copy_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  assign period    = (cell_clocks == '0) ? ledsd_pkg::CELLCLK_W'(1) : cell_clocks;
  assign phase_inc = phase + ledsd_pkg::CELLCLK_W'(1);
  assign cell_fire = phase_inc >= period;

  always_comb begin
    if (in_latch) begin
      last_cell = ({1'b0, latch_cnt} + (ledsd_pkg::LATCH_W + 1)'(1)) ==
                  {1'b0, frame_latch};
    end else begin
      last_cell = (sub_cell == ledsd_pkg::SUB_LOW) &&
                  (bit_num == ledsd_pkg::BIT_W'(ledsd_pkg::BITS_PER_LED - 1)) &&
                  (led_inc == frame_leds) && (frame_latch == '0);
    end
  end

  always_comb begin
    case (sub_cell)
      ledsd_pkg::SUB_HIGH: cell_level = 1'b1;
      ledsd_pkg::SUB_DATA: cell_level = shift_word[ledsd_pkg::PIX_W-1];
      default:             cell_level = 1'b0;
    endcase
  end

  always_comb begin
    wire_level_next  = wire_level;
    sending_next     = sending;
    phase_next       = phase;
    sub_cell_next    = sub_cell;
    bit_num_next     = bit_num;
    led_num_next     = led_num;
    in_latch_next    = in_latch;
    latch_cnt_next   = latch_cnt;
    shift_word_next  = shift_word;
    frame_leds_next  = frame_leds;
    frame_latch_next = frame_latch;
    done_now         = 1'b0;

    // The first LED's word is caught as it is written into the frame store.
    if (copy_we && (copy_waddr == '0)) begin
      shift_word_next = frame_wdata;
    end

    if (cmd.accept) begin
      unique case (cmd.act)
        ledsd_pkg::ACT_TICK: begin
          if (sending) begin
            if (cell_fire) begin
              phase_next = '0;
              if (!in_latch) begin
                wire_level_next = cell_level;
                if (sub_cell == ledsd_pkg::SUB_LOW) begin
                  sub_cell_next   = ledsd_pkg::SUB_HIGH;
                  shift_word_next = {shift_word[ledsd_pkg::PIX_W-2:0], 1'b0};
                  if (bit_num == ledsd_pkg::BIT_W'(ledsd_pkg::BITS_PER_LED - 1)) begin
                    bit_num_next = '0;
                    led_num_next = led_inc;
                    if (led_inc == frame_leds) begin
                      in_latch_next = 1'b1;
                    end else begin
                      shift_word_next = frame_rdata;
                    end
                  end else begin
                    bit_num_next = bit_num + ledsd_pkg::BIT_W'(1);
                  end
                end else if (sub_cell == ledsd_pkg::SUB_HIGH) begin
                  sub_cell_next = ledsd_pkg::SUB_DATA;
                end else begin
                  sub_cell_next = ledsd_pkg::SUB_LOW;
                end
              end else begin
                latch_cnt_next = latch_cnt + ledsd_pkg::LATCH_W'(1);
              end
              if (last_cell) begin
                wire_level_next = 1'b0;
                sending_next    = 1'b0;
                done_now        = 1'b1;
              end
            end else begin
              phase_next = phase_inc;
            end
          end
        end
        ledsd_pkg::ACT_SHOW: begin
          frame_leds_next  = active_leds;
          frame_latch_next = latch_length;
          led_num_next     = '0;
          bit_num_next     = '0;
          sub_cell_next    = ledsd_pkg::SUB_HIGH;
          latch_cnt_next   = '0;
          in_latch_next    = (active_leds == '0);
          phase_next       = '0;
          wire_level_next  = 1'b0;
          sending_next     = (active_leds != '0) || (latch_length != '0);
        end
        default: begin
          // Pixel writes and clears touch only the pixel store.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count    <= ledsd_pkg::LED_COUNT_RST;
      latch_length <= ledsd_pkg::LATCH_LENGTH_RST;
      cell_clocks  <= ledsd_pkg::CELL_CLOCKS_RST;
      pix_valid    <= '0;
      copy_cnt     <= '0;
      copy_we      <= 1'b0;
      frame_leds   <= '0;
      frame_latch  <= '0;
      led_num      <= '0;
      bit_num      <= '0;
      sub_cell     <= ledsd_pkg::SUB_HIGH;
      latch_cnt    <= '0;
      in_latch     <= 1'b0;
      phase        <= '0;
      sending      <= 1'b0;
      wire_level   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ledsd_pkg::REG_LED_COUNT:    led_count    <= cfg_data[ledsd_pkg::LEDCNT_W-1:0];
          ledsd_pkg::REG_LATCH_LENGTH: latch_length <= cfg_data[ledsd_pkg::LATCH_W-1:0];
          ledsd_pkg::REG_CELL_CLOCKS:  cell_clocks  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (cmd.accept && (cmd.act == ledsd_pkg::ACT_CLEAR)) begin
        pix_valid <= '0;
      end else if (pix_we) begin
        pix_valid[led_index[ledsd_pkg::LED_AW-1:0]] <= 1'b1;
      end

      if (cmd.copy_rd) begin
        copy_cnt <= copy_cnt + ledsd_pkg::LED_AW'(1);
      end
      copy_we <= cmd.copy_rd;

      frame_leds  <= frame_leds_next;
      frame_latch <= frame_latch_next;
      led_num     <= led_num_next;
      bit_num     <= bit_num_next;
      sub_cell    <= sub_cell_next;
      latch_cnt   <= latch_cnt_next;
      in_latch    <= in_latch_next;
      phase       <= phase_next;
      sending     <= sending_next;
      wire_level  <= wire_level_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    copy_waddr <= copy_cnt;
    copy_vld   <= pix_valid[copy_cnt];
    shift_word <= shift_word_next;
    if (cmd.accept) begin
      res_pin  <= wire_level_next;
      res_busy <= sending_next;
      res_done <= done_now;
    end
  end

endmodule

[src/addressable_led_strip_driver.sv]
// ----------------------------------------------------------------------------
// addressable_led_strip_driver
// Single-wire driver for a chain of addressable RGB LEDs.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream with their kind in s_axis_tuser: a
// clock tick, a pixel write, a store clear or a frame show. Every request
// returns exactly one result on the master stream carrying the data wire
// level, the busy flag and, in tlast, the pulse that marks the tick on
// which the last cell of a frame was applied. Ticks, pixel writes and
// clears leave the sequencer idle, so a steady stream of ticks is taken at
// one per clock as long as results are drained. A show moves the sequencer
// through a copy sweep that reads every store entry and then a write-back
// step, during which no request is taken: the pixel store is copied word
// by word through the single read port of its RAM into the frame store.
// The show result is delivered right away. Each data bit is
// sent as three cells (high, data, low), green, red, blue, MSB first,
// followed by latch_length low cells, one cell every cell_clocks ticks.
// Configuration registers are written through the cfg port, which is
// always ready; they should be changed only while no request is in flight.
// ----------------------------------------------------------------------------
module addressable_led_strip_driver (
  input  logic                                 clk,
  input  logic                                 rst,
  // Request stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: led_index[5:0], red[13:6], green[21:14], blue[29:22], zero[31:30]
  input  logic [ledsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: action[1:0]
  input  logic [ledsd_pkg::ACT_W-1:0]          s_axis_tuser,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: pin_level[0], busy_res[1], zero[7:2]
  output logic [ledsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tlast: frame_done
  output logic                                 m_axis_tlast,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ledsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ledsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ledsd_pkg::ctrl_cmd_t  cmd;
  ledsd_pkg::dp_status_t status;
  logic                  res_pin;
  logic                  res_busy;
  logic                  res_done;

  // Configuration registers have no side effects that could collide with
  // traffic, so every write is taken at once.
  assign cfg_ready = 1'b1;

  ledsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ledsd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .led_index (s_axis_tdata[5:0]),
    .red       (s_axis_tdata[13:6]),
    .green     (s_axis_tdata[21:14]),
    .blue      (s_axis_tdata[29:22]),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_pin   (res_pin),
    .res_busy  (res_busy),
    .res_done  (res_done)
  );

  assign m_axis_tdata = {{(ledsd_pkg::OUT_DATA_W - 2){1'b0}}, res_busy, res_pin};
  assign m_axis_tlast = res_done;

  // The completing tick leaves the frame finished, with the line idle low.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tdata[1] && !m_axis_tdata[0]))
    else $error("frame_done reported while the frame is still active");

  // With no frame in progress the line is always low.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> !m_axis_tdata[0])
    else $error("data line high while idle");

  // A show request starts the copy sweep, which holds off further requests.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == ledsd_pkg::ACT_SHOW)) |=> !s_axis_tready)
    else $error("request taken during the frame copy");

endmodule

[bench/led_strip_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_monitor
// Watches the request, result and register channels of the LED strip driver,
// predicts the wire level, busy flag and frame-done pulse of every request and
// compares each result with the oldest open prediction.
// ----------------------------------------------------------------------------
module led_strip_monitor (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  // tdata: led_index[5:0], red[13:6], green[21:14], blue[29:22], zero[31:30]
  input  logic [ledsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: action[1:0]
  input  logic [ledsd_pkg::ACT_W-1:0]          s_axis_tuser,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: pin_level[0], busy_res[1], zero[7:2]
  input  logic [ledsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                 m_axis_tlast,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [ledsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ledsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                   wire_mismatches,
  output int                                   results_due
);
  import ledsd_pkg::*;

  localparam int CELLS_PER_BIT = 3;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic pin_level;
    logic busy;
    logic frame_done;
  } wire_state_t;

  logic [PIX_W-1:0]     pixel_store [MAX_LEDS];
  logic [PIX_W-1:0]     frame_store [MAX_LEDS];
  int unsigned          cell_pos;
  int unsigned          frame_leds;
  int unsigned          frame_latch;
  logic [15:0]          phase_count;
  logic                 sending;
  logic                 wire_level;
  logic [LEDCNT_W-1:0]  led_count;
  logic [LATCH_W-1:0]   latch_length;
  logic [CELLCLK_W-1:0] cell_clocks;
  wire_state_t          wire_states_due [$];
  int                   results_seen;

  function automatic int unsigned clamped_leds();
    return (led_count > MAX_LEDS) ? MAX_LEDS : led_count;
  endfunction

  // Advances the strip state by one request and returns the result it gives.
  function automatic wire_state_t next_wire_state(action_t act, logic [IDX_W-1:0] idx,
                                                  logic [COLOR_W-1:0] red,
                                                  logic [COLOR_W-1:0] green,
                                                  logic [COLOR_W-1:0] blue);
    wire_state_t          res;
    logic [CELLCLK_W-1:0] period;
    int unsigned          frame_cells;
    int unsigned          bit_no;
    logic                 data_bit;
    res.frame_done = 1'b0;
    case (act)
      ACT_TICK: begin
        if (sending) begin
          period      = (cell_clocks == '0) ? CELLCLK_W'(1) : cell_clocks;
          frame_cells = frame_leds * BITS_PER_LED * CELLS_PER_BIT + frame_latch;
          phase_count = phase_count + 1'b1;
          if (phase_count >= period) begin
            phase_count = '0;
            bit_no = cell_pos / CELLS_PER_BIT;
            // Latch cells leave the line where it is, which is low.
            if (bit_no < frame_leds * BITS_PER_LED) begin
              data_bit = frame_store[bit_no / BITS_PER_LED][PIX_W - 1 - bit_no % BITS_PER_LED];
              case (sub_cell_t'(cell_pos % CELLS_PER_BIT))
                SUB_HIGH: wire_level = 1'b1;
                SUB_DATA: wire_level = data_bit;
                default:  wire_level = 1'b0;
              endcase
            end
            cell_pos++;
            if (cell_pos >= frame_cells) begin
              wire_level     = 1'b0;
              sending        = 1'b0;
              res.frame_done = 1'b1;
            end
          end
        end
      end
      ACT_WRITE: begin
        if (idx < clamped_leds()) pixel_store[idx] = {green, red, blue};
      end
      ACT_CLEAR: begin
        foreach (pixel_store[i]) pixel_store[i] = '0;
      end
      default: begin
        frame_store = pixel_store;
        frame_leds  = clamped_leds();
        frame_latch = latch_length;
        cell_pos    = 0;
        phase_count = '0;
        wire_level  = 1'b0;
        sending     = (frame_leds * BITS_PER_LED * CELLS_PER_BIT + frame_latch) != 0;
      end
    endcase
    res.pin_level = wire_level;
    res.busy      = sending;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (wire_mismatches < PRINT_LIMIT) $display("[%0t] result %0d: %s", $time, results_seen, msg);
    wire_mismatches++;
  endtask

  always @(posedge clk) begin
    wire_state_t seen;
    wire_state_t want;
    if (rst) begin
      foreach (pixel_store[i]) pixel_store[i] = '0;
      foreach (frame_store[i]) frame_store[i] = '0;
      cell_pos        = 0;
      frame_leds      = 0;
      frame_latch     = 0;
      phase_count     = '0;
      sending         = 1'b0;
      wire_level      = 1'b0;
      led_count       = LED_COUNT_RST;
      latch_length    = LATCH_LENGTH_RST;
      cell_clocks     = CELL_CLOCKS_RST;
      results_seen    = 0;
      wire_mismatches = 0;
      wire_states_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_LED_COUNT:    led_count    = cfg_data[LEDCNT_W-1:0];
          REG_LATCH_LENGTH: latch_length = cfg_data[LATCH_W-1:0];
          REG_CELL_CLOCKS:  cell_clocks  = cfg_data[CELLCLK_W-1:0];
          default: ;
        endcase
      end
      // Predict first so that a result returned on the request's own edge still matches.
      if (s_axis_tvalid && s_axis_tready) begin
        wire_states_due.push_back(next_wire_state(action_t'(s_axis_tuser), s_axis_tdata[5:0],
                                                  s_axis_tdata[13:6], s_axis_tdata[21:14],
                                                  s_axis_tdata[29:22]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{pin_level: m_axis_tdata[0], busy: m_axis_tdata[1], frame_done: m_axis_tlast};
        if (wire_states_due.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = wire_states_due.pop_front();
          if (seen.pin_level !== want.pin_level)
            report_mismatch($sformatf("pin_level %b, expected %b", seen.pin_level,
                                      want.pin_level));
          if (seen.busy !== want.busy)
            report_mismatch($sformatf("busy %b, expected %b", seen.busy, want.busy));
          if (seen.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, expected %b", seen.frame_done,
                                      want.frame_done));
        end
        results_seen++;
      end
    end
    results_due <= wire_states_due.size();
  end

endmodule

[bench/addressable_led_strip_driver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_strip_driver_test
// Drives pixel writes, clears, frame shows and clock ticks into the LED strip
// driver under a range of register settings and lets the monitor check every
// result against its own prediction of the data wire.
// ----------------------------------------------------------------------------
module addressable_led_strip_driver_test;
  import ledsd_pkg::*;

  // The run is cut off here; a correct run needs only a small part of it.
  localparam int RUN_LIMIT   = 500_000;
  // A show keeps the block busy copying after it is taken, so registers are
  // only touched once this many quiet cycles have passed.
  localparam int COPY_SETTLE = 80;
  // Frames longer than this many ticks are only partly sent before moving on.
  localparam int TICK_CAP    = 80;
  localparam int PHASES      = 7;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [ACT_W-1:0]      s_axis_tuser  = ACT_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_LED_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  int                    wire_mismatches;
  int                    results_due;

  // When set, both the request side and the result side pause at random.
  logic                  idle_on       = 1'b1;
  int                    stall_left    = 0;
  int                    cycle_count   = 0;
  int                    requests_sent = 0;

  // Register values last written, used only to size the tick runs.
  int unsigned           led_count_now = LED_COUNT_RST;
  int unsigned           latch_now     = LATCH_LENGTH_RST;
  int unsigned           cell_now      = CELL_CLOCKS_RST;

  // Settings of the random phases: LED count, latch cells, clocks per cell and
  // the number of requests after which the phase stops starting new sequences.
  // They cover an empty LED chain, a count above the store size, the longest
  // latch and cell period, and a zero period that behaves like one clock.
  int unsigned phase_leds  [PHASES] = '{1, 0, 64,    127, 1, 2, 0};
  int unsigned phase_latch [PHASES] = '{2, 5, 4095,  0,   0, 1, 30};
  int unsigned phase_cell  [PHASES] = '{1, 0, 65535, 1,   1, 1, 2};
  int          phase_quota [PHASES] = '{60, 25, 15,  15,  60, 60, 60};

  addressable_led_strip_driver u_dut (.*);

  led_strip_monitor u_monitor (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: reaching it means the block stopped taking requests or
  // stopped returning results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: ready stays high except for random stall bursts while
  // idling is allowed.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && m_axis_tready && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Presents one request and holds it until the block takes it. A random gap
  // may come first; tvalid stays high between back-to-back requests.
  task automatic send_request(action_t act, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] red,
                              logic [COLOR_W-1:0] green, logic [COLOR_W-1:0] blue);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, blue, green, red, idx};
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  // A request of the given kind with random index and color. Ticks, clears
  // and shows ignore these fields, which still toggles every bit of them.
  task automatic send_random(action_t act);
    send_request(act, IDX_W'($urandom_range(0, 63)), COLOR_W'($urandom_range(0, 255)),
                 COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
  endtask

  // Stops requesting and waits until every result is in and a show copy
  // that may still run inside the block has finished.
  task automatic settle_all();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (COPY_SETTLE) @(posedge clk);
  endtask

  // Writes all three registers back to back; call only when settled. A frame
  // may still be running, which exercises a period change mid-frame.
  task automatic configure(int unsigned leds, int unsigned latch, int unsigned cell_clk);
    reg_idx_t              reg_list [3] = '{REG_LED_COUNT, REG_LATCH_LENGTH, REG_CELL_CLOCKS};
    logic [CFG_DATA_W-1:0] val_list [3];
    val_list = '{CFG_DATA_W'(leds), CFG_DATA_W'(latch), CFG_DATA_W'(cell_clk)};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_list[r];
      cfg_data  <= val_list[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid     <= 1'b0;
    led_count_now = leds;
    latch_now     = latch;
    cell_now      = cell_clk;
  endtask

  // The usual life of a strip: a few pixel writes, a show, then enough ticks
  // to send the frame and go idle. One time in four the tick run is cut short
  // so the next show lands on a running frame. Writes and clears are mixed
  // into the ticks to check that the frame in flight does not change.
  task automatic run_frame_sequence();
    int unsigned frame_ticks;
    int unsigned ticks;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 7) == 0) send_random(ACT_CLEAR);
      else send_random(ACT_WRITE);
    end
    send_random(ACT_SHOW);
    // Each LED sends 24 bits of three cells each.
    frame_ticks = ((led_count_now > MAX_LEDS ? MAX_LEDS : led_count_now) * BITS_PER_LED * 3
                   + latch_now) * (cell_now == 0 ? 1 : cell_now);
    ticks = (frame_ticks > TICK_CAP ? TICK_CAP : frame_ticks) + $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) ticks = $urandom_range(1, ticks);
    repeat (ticks) begin
      case ($urandom_range(0, 39))
        0, 1:    send_random(ACT_WRITE);
        2:       send_random(ACT_CLEAR);
        default: send_random(ACT_TICK);
      endcase
    end
  endtask

  initial begin
    int phase_end;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: no LEDs, so the write falls outside the chain and
    // the show sends only latch cells at the default period.
    send_request(ACT_WRITE, 6'd0, 8'hFF, 8'hFF, 8'hFF);
    send_random(ACT_SHOW);
    send_random(ACT_TICK);
    send_random(ACT_TICK);
    settle_all();

    // Two LEDs and one clock per cell, entered while the latch frame runs.
    configure(2, 3, 1);
    send_request(ACT_WRITE, 6'd0, 8'hFF, 8'h00, 8'hFF);
    send_request(ACT_WRITE, 6'd1, 8'h00, 8'hFF, 8'h00);
    // Index equal to the count, and the top index, are both ignored.
    send_request(ACT_WRITE, 6'd2, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    send_random(ACT_SHOW);
    repeat (4) send_random(ACT_TICK);
    // Clear and rewrite during the frame touch only the pixel store.
    send_random(ACT_CLEAR);
    send_random(ACT_TICK);
    send_request(ACT_WRITE, 6'd1, 8'h5A, 8'hA5, 8'h3C);
    // Show on a running frame restarts from the first cell.
    send_random(ACT_SHOW);
    repeat (2) send_random(ACT_TICK);
    settle_all();

    // Empty frame: nothing to send, so the block stays idle with no pulse.
    configure(0, 0, 0);
    send_random(ACT_SHOW);
    send_random(ACT_TICK);
    send_random(ACT_TICK);
    settle_all();

    // Random phases. Most stimulus is well-formed frame sequences; about one
    // sequence in eight is a short burst of arbitrary requests instead. The
    // last phase runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      configure(phase_leds[p], phase_latch[p], phase_cell[p]);
      phase_end = requests_sent + phase_quota[p];
      while (requests_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(3, 8)) send_random(action_t'($urandom_range(0, 3)));
        end else begin
          run_frame_sequence();
        end
      end
      settle_all();
    end

    if (wire_mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/ledsd_pkg.sv
src/ledsd_ram.sv
src/ledsd_ctrl.sv
src/ledsd_datapath.sv
src/addressable_led_strip_driver.sv
bench/led_strip_monitor.sv
bench/addressable_led_strip_driver_test.sv
